// ===== hw/rtl/synth_voice_allocator_assert.svh =====
// Assertion macros used by the checker file.
`ifndef SYNTH_VOICE_ALLOCATOR_ASSERT_SVH
`define SYNTH_VOICE_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, masked while reset is asserted.
`define SVA_HOLDS(name, clk, rst_n, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("voice allocator check failed");

// Next-cycle implication, masked while reset is asserted.
`define SVA_NEXT(name, clk, rst_n, cond, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("voice allocator check failed");

// What must hold in the cycle after a reset cycle.
`define SVA_AFTER_RESET(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) (!rst_n) |=> (prop)) \
        else $error("voice allocator reset check failed");

`endif

// ===== hw/rtl/svalloc_pkg.sv =====
package svalloc_pkg;

    localparam int unsigned VOICES_DEFAULT      = 6;
    localparam int unsigned STACK_DEPTH_DEFAULT = 16;

    localparam int unsigned NOTE_W  = 7;
    localparam int unsigned VNOTE_W = 8;
    localparam int unsigned IDLE_W  = 6;
    localparam int unsigned VOICE_W = 3;
    localparam int unsigned CMD_W   = 2;
    localparam int unsigned MODE_W  = 3;

    localparam logic [VNOTE_W-1:0] NO_NOTE = 8'hFF;

    localparam logic [MODE_W-1:0] MODE_POLY_RR   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_POLY_IDLE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MONO      = 3'd2;
    localparam logic [MODE_W-1:0] MODE_LEGATO    = 3'd3;
    localparam logic [MODE_W-1:0] MODE_UNISON    = 3'd4;

    localparam logic ACT_NOTE_ON  = 1'b0;
    localparam logic ACT_NOTE_OFF = 1'b1;

    localparam logic [CMD_W-1:0] CMD_ATTACK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_GLIDE   = 2'd2;

    typedef struct packed {
        logic              action;
        logic [NOTE_W-1:0] note;
        logic [IDLE_W-1:0] voice_idle_mask;
    } t_in_item;

    typedef struct packed {
        logic [VOICE_W-1:0] voice;
        logic [NOTE_W-1:0]  assigned_note;
        logic [CMD_W-1:0]   command;
        logic               snap_pitch;
        logic               last;
    } t_out_item;

    // per-voice update strobes
    typedef struct packed {
        logic set_note;
        logic set_gate;
        logic clr_gate;
    } t_vc_ctl;

    // stack operation, common to all stack cells
    typedef struct packed {
        logic push;
        logic remove;
    } t_sc_ctl;

endpackage

// ===== hw/rtl/svalloc_voice_cell.sv =====
module svalloc_voice_cell
    import svalloc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_vc_ctl            i_ctl,
    input  logic [NOTE_W-1:0]  i_ev_note,
    input  logic [NOTE_W-1:0]  i_new_note,
    input  logic               i_idle,
    input  logic               i_busy_seen,
    input  logic               i_idle_seen,
    output logic               o_busy_seen,
    output logic               o_idle_seen,
    output logic               o_busy_first,
    output logic               o_idle_first,
    output logic               o_release,
    output logic               o_gate,
    output logic [VNOTE_W-1:0] o_note
);

    logic [VNOTE_W-1:0] r_note;
    logic               r_gate;
    logic               same_note;
    logic               busy;

    assign same_note    = (r_note == {1'b0, i_ev_note});
    assign busy         = same_note & ~i_idle;
    // priority chains: first sounding voice on this note, first idle voice
    assign o_busy_first = busy & ~i_busy_seen;
    assign o_busy_seen  = i_busy_seen | busy;
    assign o_idle_first = i_idle & ~i_idle_seen;
    assign o_idle_seen  = i_idle_seen | i_idle;
    assign o_release    = r_gate & same_note;
    assign o_gate       = r_gate;
    assign o_note       = r_note;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_note <= NO_NOTE;
            r_gate <= 1'b0;
        end else begin
            if (i_ctl.set_note) begin
                r_note <= {1'b0, i_new_note};
            end
            if (i_ctl.clr_gate) begin
                r_gate <= 1'b0;
            end else if (i_ctl.set_gate) begin
                r_gate <= 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/svalloc_stack_cell.sv =====
module svalloc_stack_cell
    import svalloc_pkg::*;
#(
    parameter int unsigned DEPTH = STACK_DEPTH_DEFAULT,
    parameter int unsigned IDX   = 0
) (
    input  logic                       i_clk,
    input  t_sc_ctl                    i_ctl,
    input  logic [$clog2(DEPTH+1)-1:0] i_count,
    input  logic [NOTE_W-1:0]          i_ev_note,
    input  logic [NOTE_W-1:0]          i_right_note,
    input  logic                       i_found_seen,
    output logic                       o_found_seen,
    output logic                       o_top_hit,
    output logic [NOTE_W-1:0]          o_note
);

    localparam int unsigned       CW     = $clog2(DEPTH + 1);
    localparam logic [CW-1:0]     MY_IDX = CW'(IDX);
    localparam logic [CW-1:0]     LAST   = CW'(DEPTH - 1);

    logic [NOTE_W-1:0] r_note;
    logic              in_range;
    logic              match;
    logic              full;

    assign in_range     = (MY_IDX < i_count);
    assign match        = in_range && (r_note == i_ev_note);
    // oldest match wins; everything from it upward shifts down on removal
    assign o_found_seen = i_found_seen | match;
    assign o_top_hit    = match & ~i_found_seen & ((MY_IDX + CW'(1)) == i_count);
    assign full         = (i_count == CW'(DEPTH));
    assign o_note       = r_note;

    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            if (full) begin
                // drop oldest, new note lands on top
                r_note <= (MY_IDX == LAST) ? i_ev_note : i_right_note;
            end else if (MY_IDX == i_count) begin
                r_note <= i_ev_note;
            end
        end else if (i_ctl.remove && o_found_seen) begin
            r_note <= i_right_note;
        end
    end

endmodule

// ===== hw/rtl/synth_voice_allocator.sv =====
// Channel | Direction | Handshake                  | Payload
// --------+-----------+----------------------------+------------------------
// in      | input     | i_in_valid / o_in_stall    | i_in_item  (t_in_item)
// out     | output    | o_out_valid / i_out_stall  | o_out_item (t_out_item)
// cfg     | input     | i_cfg_we (no wait)         | i_cfg_wdata (voice mode)
//
// One item at a time: an accept state, an evaluate state in which the stack
// cells and voice cells resolve their priority chains and update, then one
// result per cycle through the output register while the output does not
// stall. An item that gives no result goes straight back to accept.
// Output stalls hold the result sequencer in place.
// Reset is synchronous, active low; there is no clearing pass, the stack
// entries stay undefined until pushed and are only read below the fill count.
module synth_voice_allocator
    import svalloc_pkg::*;
#(
    parameter int unsigned VOICES      = VOICES_DEFAULT,
    parameter int unsigned STACK_DEPTH = STACK_DEPTH_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [MODE_W-1:0] i_cfg_wdata,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  t_in_item          i_in_item,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output t_out_item         o_out_item
);

    localparam int unsigned VW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int unsigned CW = $clog2(STACK_DEPTH + 1);
    localparam int unsigned IW = $clog2(STACK_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_EMIT
    } t_state;

    // control
    t_state             r_state;
    logic [MODE_W-1:0]  r_mode;
    logic [CW-1:0]      r_count;    // stack fill
    logic [VW-1:0]      r_rr;       // round-robin pointer
    logic [VOICES-1:0]  r_emit;     // voices still to report
    logic               r_out_valid;
    // payload
    t_in_item           r_item;
    logic [VOICES-1:0]  r_snap;
    logic [CMD_W-1:0]   r_cmd;
    logic [NOTE_W-1:0]  r_note;
    t_out_item          r_out;

    // evaluate results
    logic [CW-1:0]      n_count;
    logic [VW-1:0]      n_rr;
    logic [VOICES-1:0]  n_emit;
    logic [VOICES-1:0]  n_snap;
    logic [CMD_W-1:0]   n_cmd;
    logic [NOTE_W-1:0]  n_note;

    logic               mode_stack;
    logic               mode_unison;
    logic               mode_rr;
    logic               ev_on;
    logic [NOTE_W-1:0]  ev_note;

    // voice row
    t_vc_ctl            vctl [VOICES];
    logic [NOTE_W-1:0]  vc_new_note;
    logic [VOICES:0]    busy_seen;
    logic [VOICES:0]    idle_seen;
    logic [VOICES-1:0]  busy_first;
    logic [VOICES-1:0]  idle_first;
    logic [VOICES-1:0]  v_release;
    logic [VOICES-1:0]  v_gate;
    logic [VOICES-1:0]  v_idle;
    logic [VOICES-1:0]  rr_onehot;
    logic [VOICES-1:0]  tgt;
    logic [VNOTE_W-1:0] v_note [VOICES];
    logic [VW-1:0]      rr_next;

    // stack row
    t_sc_ctl            sctl;
    logic [STACK_DEPTH:0]   found_seen;
    logic [STACK_DEPTH-1:0] top_hit;
    logic [NOTE_W-1:0]  s_note [STACK_DEPTH];
    logic [CW-1:0]      below_top_idx;
    logic [NOTE_W-1:0]  below_top;
    logic               stack_full;

    // result sequencer
    logic [VOICES-1:0]  lowest;
    logic [VW-1:0]      low_idx;
    logic [VW+VOICE_W-1:0] voice_ext;
    logic               emit_last;
    logic               out_free;
    t_out_item          out_next;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    assign ev_on   = (r_item.action == ACT_NOTE_ON);
    assign ev_note = r_item.note;

    // unused codes behave as poly idle-first
    always_comb begin
        mode_stack  = 1'b0;
        mode_unison = 1'b0;
        mode_rr     = 1'b0;
        case (r_mode)
            MODE_POLY_RR:          mode_rr     = 1'b1;
            MODE_POLY_IDLE:        mode_rr     = 1'b0;
            MODE_MONO, MODE_LEGATO: mode_stack = 1'b1;
            MODE_UNISON:           mode_unison = 1'b1;
            default:               mode_rr     = 1'b0;
        endcase
    end

    //------------------------------------------------------------------
    // Voice cells: one per voice, chained for first-match / first-idle
    //------------------------------------------------------------------
    assign busy_seen[0] = 1'b0;
    assign idle_seen[0] = 1'b0;

    for (genvar gv = 0; gv < VOICES; gv++) begin : g_voice
        // voices past the idle mask never report idle
        if (gv < IDLE_W) begin : g_idle
            assign v_idle[gv] = r_item.voice_idle_mask[gv];
        end else begin : g_noidle
            assign v_idle[gv] = 1'b0;
        end

        svalloc_voice_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (vctl[gv]),
            .i_ev_note    (ev_note),
            .i_new_note   (vc_new_note),
            .i_idle       (v_idle[gv]),
            .i_busy_seen  (busy_seen[gv]),
            .i_idle_seen  (idle_seen[gv]),
            .o_busy_seen  (busy_seen[gv+1]),
            .o_idle_seen  (idle_seen[gv+1]),
            .o_busy_first (busy_first[gv]),
            .o_idle_first (idle_first[gv]),
            .o_release    (v_release[gv]),
            .o_gate       (v_gate[gv]),
            .o_note       (v_note[gv])
        );
    end

    //------------------------------------------------------------------
    // Stack cells: index 0 is the oldest note, removal shifts down
    //------------------------------------------------------------------
    assign found_seen[0] = 1'b0;

    for (genvar gs = 0; gs < STACK_DEPTH; gs++) begin : g_stack
        logic [NOTE_W-1:0] right_note;

        if (gs == STACK_DEPTH - 1) begin : g_end
            assign right_note = s_note[gs];
        end else begin : g_mid
            assign right_note = s_note[gs+1];
        end

        svalloc_stack_cell #(
            .DEPTH (STACK_DEPTH),
            .IDX   (gs)
        ) u_cell (
            .i_clk        (i_clk),
            .i_ctl        (sctl),
            .i_count      (r_count),
            .i_ev_note    (ev_note),
            .i_right_note (right_note),
            .i_found_seen (found_seen[gs]),
            .o_found_seen (found_seen[gs+1]),
            .o_top_hit    (top_hit[gs]),
            .o_note       (s_note[gs])
        );
    end

    assign stack_full    = (r_count == CW'(STACK_DEPTH));
    // entry just under the top; only used with two or more notes held
    assign below_top_idx = r_count - CW'(2);
    assign below_top     = s_note[below_top_idx[IW-1:0]];

    assign rr_next = (r_rr == VW'(VOICES - 1)) ? '0 : r_rr + VW'(1);

    always_comb begin
        for (int i = 0; i < VOICES; i++) begin
            rr_onehot[i] = (r_rr == VW'(i));
        end
    end

    //------------------------------------------------------------------
    // Evaluate: decide commands, update cells, load the result set
    //------------------------------------------------------------------
    always_comb begin
        n_count     = r_count;
        n_rr        = r_rr;
        n_emit      = '0;
        n_snap      = '0;
        n_cmd       = CMD_ATTACK;
        n_note      = ev_note;
        vc_new_note = ev_note;
        sctl        = '0;
        tgt         = '0;
        for (int i = 0; i < VOICES; i++) begin
            vctl[i].set_note = 1'b0;
            vctl[i].set_gate = 1'b0;
            vctl[i].clr_gate = i_cfg_we;   // mode write drops every gate
        end

        if (r_state == S_EVAL) begin
            if (ev_on) begin
                if (mode_stack) begin
                    sctl.push        = 1'b1;
                    n_count          = stack_full ? r_count : r_count + CW'(1);
                    vctl[0].set_note = 1'b1;
                    vctl[0].set_gate = 1'b1;
                    n_emit[0]        = 1'b1;
                    if (r_mode == MODE_MONO) begin
                        n_snap[0] = ~v_gate[0];
                    end else if (r_count == '0) begin
                        n_snap[0] = 1'b1;
                    end else begin
                        n_cmd = CMD_GLIDE;
                    end
                end else if (mode_unison) begin
                    for (int i = 0; i < VOICES; i++) begin
                        vctl[i].set_note = 1'b1;
                        vctl[i].set_gate = 1'b1;
                    end
                    n_emit = '1;
                    n_snap = ~v_gate;
                end else if (busy_seen[VOICES]) begin
                    // same note still sounding: retrigger that voice only
                    for (int i = 0; i < VOICES; i++) begin
                        vctl[i].set_gate = busy_first[i];
                    end
                    n_emit = busy_first;
                end else begin
                    if (!mode_rr && idle_seen[VOICES]) begin
                        tgt = idle_first;
                    end else begin
                        tgt  = rr_onehot;
                        n_rr = rr_next;
                    end
                    for (int i = 0; i < VOICES; i++) begin
                        vctl[i].set_note = tgt[i];
                        vctl[i].set_gate = tgt[i];
                    end
                    n_emit = tgt;
                    n_snap = tgt & v_idle;
                end
            end else if (mode_stack) begin
                if (found_seen[STACK_DEPTH]) begin
                    sctl.remove = 1'b1;
                    n_count     = r_count - CW'(1);
                    if (r_count == CW'(1)) begin
                        vctl[0].clr_gate = 1'b1;
                        n_emit[0]        = 1'b1;
                        n_cmd            = CMD_RELEASE;
                        n_note           = v_note[0][NOTE_W-1:0];
                    end else if (|top_hit) begin
                        // fall back to the previous held note
                        vc_new_note      = below_top;
                        vctl[0].set_note = 1'b1;
                        n_emit[0]        = 1'b1;
                        n_cmd            = (r_mode == MODE_MONO) ? CMD_ATTACK : CMD_GLIDE;
                        n_note           = below_top;
                    end
                end
            end else begin
                for (int i = 0; i < VOICES; i++) begin
                    vctl[i].clr_gate = vctl[i].clr_gate | v_release[i];
                end
                n_emit = v_release;
                n_cmd  = CMD_RELEASE;
            end
        end
    end

    //------------------------------------------------------------------
    // Result sequencer: lowest pending voice first
    //------------------------------------------------------------------
    assign lowest    = r_emit & (~r_emit + VOICES'(1));
    assign emit_last = ((r_emit & ~lowest) == '0);
    assign out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        low_idx = '0;
        for (int i = 0; i < VOICES; i++) begin
            if (lowest[i]) begin
                low_idx = VW'(i);
            end
        end
    end

    assign voice_ext = {{VOICE_W{1'b0}}, low_idx};

    always_comb begin
        out_next.voice         = voice_ext[VOICE_W-1:0];
        out_next.assigned_note = r_note;
        out_next.command       = r_cmd;
        out_next.snap_pitch    = |(lowest & r_snap);
        out_next.last          = emit_last;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= MODE_POLY_RR;
            r_count     <= '0;
            r_rr        <= '0;
            r_emit      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // output register: load a new result or drain the taken one
            if (r_state == S_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_item  <= i_in_item;
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    r_rr    <= n_rr;
                    r_emit  <= n_emit;
                    r_snap  <= n_snap;
                    r_cmd   <= n_cmd;
                    r_note  <= n_note;
                    r_state <= (n_emit != '0) ? S_EMIT : S_IDLE;
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_out       <= out_next;
                        r_emit      <= r_emit & ~lowest;
                        if (emit_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            // mode write empties the stack (gates cleared in the cells)
            if (i_cfg_we) begin
                r_mode  <= i_cfg_wdata;
                r_count <= '0;
            end else if (r_state == S_EVAL) begin
                r_count <= n_count;
            end
        end
    end

endmodule

// ===== hw/rtl/svalloc_checker.sv =====
`include "synth_voice_allocator_assert.svh"

module svalloc_checker
    import svalloc_pkg::*;
#(
    parameter int unsigned VOICES = VOICES_DEFAULT
) (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input t_out_item         o_out_item
);

    // one item in flight: taking an item closes the input side
    `SVA_NEXT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall)

    // a held result stays put
    `SVA_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_item))

    // releases never snap the pitch
    `SVA_HOLDS(a_release_glide, i_clk, i_rst_n, o_out_valid && (o_out_item.command == CMD_RELEASE), !o_out_item.snap_pitch)

    // voice index stays inside the voice row
    `SVA_HOLDS(a_voice_range, i_clk, i_rst_n, o_out_valid, (VOICES > 8) || (32'(o_out_item.voice) < VOICES))

    `SVA_AFTER_RESET(a_reset_quiet, i_clk, i_rst_n, !o_out_valid && !o_in_stall)

endmodule

bind synth_voice_allocator svalloc_checker #(.VOICES(VOICES)) u_svalloc_checker (.*);

// ===== tb/tb_synth_voice_allocator.sv =====
`timescale 1ns / 1ps

module tb_synth_voice_allocator;
    import svalloc_pkg::*;

    // Values 5..7 are spare mode codes; the block treats them as poly idle first.
    localparam logic [MODE_W-1:0] MODE_SPARE_LO  = 3'd5;
    localparam logic [MODE_W-1:0] MODE_SPARE_MID = 3'd6;
    localparam logic [MODE_W-1:0] MODE_SPARE_HI  = 3'd7;

    localparam int unsigned NV          = VOICES_DEFAULT;
    localparam int unsigned DEPTH       = STACK_DEPTH_DEFAULT;
    localparam int unsigned WATCHDOG    = 2000;
    localparam int unsigned NUM_PHASES  = 14;
    localparam int unsigned PHASE_ITEMS = 19;
    localparam int unsigned MAX_PRINTS  = 40;

    // ------------------------------------------------------------------
    // Allocation predictor and store of the voice commands still due.
    // ------------------------------------------------------------------
    class voice_alloc_scoreboard;
        logic [MODE_W-1:0]  mode;
        logic [NOTE_W-1:0]  held [DEPTH];
        int unsigned        held_cnt;
        logic [VNOTE_W-1:0] vnote [NV];
        bit                 gate [NV];
        int unsigned        rr_voice;
        t_out_item          due_cmds[$];
        t_out_item          batch[$];
        int unsigned        errors;

        function new();
            mode     = MODE_POLY_RR;
            held_cnt = 0;
            rr_voice = 0;
            errors   = 0;
            for (int i = 0; i < NV; i++) begin
                vnote[i] = NO_NOTE;
                gate[i]  = 1'b0;
            end
        endfunction

        function bit is_stack_mode();
            return (mode == MODE_MONO) || (mode == MODE_LEGATO);
        endfunction

        // Mode write: stack and gates cleared, voice notes and pointer kept.
        function void write_mode(logic [MODE_W-1:0] m);
            mode     = m;
            held_cnt = 0;
            for (int i = 0; i < NV; i++) gate[i] = 1'b0;
        endfunction

        function void emit(int unsigned v, logic [NOTE_W-1:0] n, logic [CMD_W-1:0] c,
                           logic s);
            t_out_item r;
            r.voice         = VOICE_W'(v);
            r.assigned_note = n;
            r.command       = c;
            r.snap_pitch    = s;
            r.last          = 1'b0;
            batch.push_back(r);
        endfunction

        function int unsigned take_rr();
            int unsigned t;
            t        = rr_voice % NV;
            rr_voice = (t + 1) % NV;
            return t;
        endfunction

        function void poly_on(logic [NOTE_W-1:0] n, logic [IDLE_W-1:0] idle);
            int unsigned t;
            // a non-idle voice already on this note is simply retriggered
            for (int i = 0; i < NV; i++) begin
                if (vnote[i] == {1'b0, n} && !idle[i]) begin
                    gate[i] = 1'b1;
                    emit(i, n, CMD_ATTACK, 1'b0);
                    return;
                end
            end
            if (mode == MODE_POLY_RR) begin
                t = take_rr();
            end else begin
                t = NV;
                for (int i = 0; i < NV; i++) begin
                    if (idle[i] && t == NV) t = i;
                end
                if (t == NV) t = take_rr();
            end
            vnote[t] = {1'b0, n};
            gate[t]  = 1'b1;
            emit(t, n, CMD_ATTACK, idle[t]);
        endfunction

        function void stack_on(logic [NOTE_W-1:0] n);
            bit was_empty;
            // full stack: oldest note falls off the bottom
            if (held_cnt >= DEPTH) begin
                for (int i = 0; i < DEPTH - 1; i++) held[i] = held[i + 1];
                held_cnt = DEPTH - 1;
            end
            was_empty      = (held_cnt == 0);
            held[held_cnt] = n;
            held_cnt++;
            vnote[0] = {1'b0, n};
            if (mode == MODE_MONO) emit(0, n, CMD_ATTACK, !gate[0]);
            else if (was_empty)    emit(0, n, CMD_ATTACK, 1'b1);
            else                   emit(0, n, CMD_GLIDE, 1'b0);
            gate[0] = 1'b1;
        endfunction

        function void stack_off(logic [NOTE_W-1:0] n);
            int found;
            bit was_top;
            found = -1;
            for (int i = 0; i < held_cnt; i++) begin
                if (found < 0 && held[i] == n) found = i;
            end
            if (found < 0) return;
            was_top = (found == held_cnt - 1);
            for (int i = found; i + 1 < held_cnt; i++) held[i] = held[i + 1];
            held_cnt--;
            if (held_cnt > 0) begin
                if (!was_top) return;
                vnote[0] = {1'b0, held[held_cnt - 1]};
                emit(0, vnote[0][NOTE_W-1:0], (mode == MODE_MONO) ? CMD_ATTACK : CMD_GLIDE,
                     1'b0);
                return;
            end
            gate[0] = 1'b0;
            emit(0, vnote[0][NOTE_W-1:0], CMD_RELEASE, 1'b0);
        endfunction

        // Accepted event: work out its voice commands and queue them.
        function void note_input(t_in_item it);
            t_out_item r;
            batch.delete();
            if (it.action == ACT_NOTE_ON) begin
                if (is_stack_mode()) begin
                    stack_on(it.note);
                end else if (mode == MODE_UNISON) begin
                    for (int i = 0; i < NV; i++) begin
                        vnote[i] = {1'b0, it.note};
                        emit(i, it.note, CMD_ATTACK, !gate[i]);
                        gate[i] = 1'b1;
                    end
                end else begin
                    poly_on(it.note, it.voice_idle_mask);
                end
            end else if (is_stack_mode()) begin
                stack_off(it.note);
            end else begin
                for (int i = 0; i < NV; i++) begin
                    if (gate[i] && vnote[i] == {1'b0, it.note}) begin
                        gate[i] = 1'b0;
                        emit(i, it.note, CMD_RELEASE, 1'b0);
                    end
                end
            end
            for (int i = 0; i < batch.size(); i++) begin
                r      = batch[i];
                r.last = (i == batch.size() - 1);
                due_cmds.push_back(r);
            end
        endfunction

        task report(string what);
            errors++;
            if (errors <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, what);
        endtask

        task check_result(t_out_item got);
            t_out_item want;
            if (due_cmds.size() == 0) begin
                report($sformatf("unexpected result voice %0d note %0d cmd %0d",
                                 got.voice, got.assigned_note, got.command));
                return;
            end
            want = due_cmds.pop_front();
            if (got.voice !== want.voice)
                report($sformatf("voice got %0d want %0d", got.voice, want.voice));
            if (got.assigned_note !== want.assigned_note)
                report($sformatf("note got %0d want %0d", got.assigned_note,
                                 want.assigned_note));
            if (got.command !== want.command)
                report($sformatf("command got %0d want %0d", got.command, want.command));
            if (got.snap_pitch !== want.snap_pitch)
                report($sformatf("snap got %0d want %0d", got.snap_pitch, want.snap_pitch));
            if (got.last !== want.last)
                report($sformatf("last got %0d want %0d", got.last, want.last));
        endtask
    endclass

    // ------------------------------------------------------------------
    // DUT and drive signals; every input known from time zero.
    // ------------------------------------------------------------------
    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_cfg_we    = 1'b0;
    logic [MODE_W-1:0] i_cfg_wdata = MODE_POLY_RR;
    logic              i_in_valid  = 1'b0;
    t_in_item          i_in_item   = '0;
    logic              i_out_stall = 1'b0;
    logic              o_in_stall;
    logic              o_out_valid;
    t_out_item         o_out_item;

    voice_alloc_scoreboard alloc_sb = new();

    bit          calm_tail  = 1'b0;   // no idling on either side near the end
    int unsigned idle_count = 0;
    int unsigned stall_left = 0;
    int unsigned run_left   = 0;

    synth_voice_allocator uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always #2 i_clk = ~i_clk;

    // Receiver back-pressure: random stall bursts between runs
    // of free flow, some of them long.
    always @(negedge i_clk) begin
        if (calm_tail) begin
            i_out_stall <= 1'b0;
        end else if (stall_left != 0) begin
            i_out_stall <= 1'b1;
            stall_left = stall_left - 1;
        end else if (run_left != 0) begin
            i_out_stall <= 1'b0;
            run_left = run_left - 1;
        end else begin
            i_out_stall <= 1'b0;
            run_left   = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 100)
                                                     : $urandom_range(0, 6);
            stall_left = $urandom_range(1, 11);
        end
    end

    // Result check and watchdog on cycles where nothing moves.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) alloc_sb.check_result(o_out_item);
            if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
                idle_count <= 0;
            end else if (idle_count + 1 >= WATCHDOG) begin
                $display("CHECK FAILED");
                $finish;
            end else begin
                idle_count <= idle_count + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_in_item mk_event(logic act, logic [NOTE_W-1:0] n,
                                          logic [IDLE_W-1:0] idle);
        t_in_item it;
        it.action          = act;
        it.note            = n;
        it.voice_idle_mask = idle;
        return it;
    endfunction

    // Mostly a narrow cluster so notes repeat; sometimes the full range.
    function automatic logic [NOTE_W-1:0] pool_note();
        if ($urandom_range(0, 2) != 0) return NOTE_W'(48 + $urandom_range(0, 7));
        return NOTE_W'($urandom_range(0, 127));
    endfunction

    function automatic logic [IDLE_W-1:0] rand_idle();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            default: return IDLE_W'($urandom_range(0, 63));
        endcase
    endfunction

    // Note-offs mostly target something actually held or sounding.
    function automatic t_in_item random_event();
        t_in_item    it;
        int unsigned pick;
        int unsigned v;
        it.voice_idle_mask = rand_idle();
        it.action          = ACT_NOTE_OFF;
        pick               = $urandom_range(0, 99);
        if (alloc_sb.is_stack_mode()) begin
            if (pick < 52) begin
                it.action = ACT_NOTE_ON;
                it.note   = pool_note();
            end else if (pick < 94 && alloc_sb.held_cnt > 0) begin
                it.note = alloc_sb.held[$urandom_range(0, alloc_sb.held_cnt - 1)];
            end else begin
                it.note = NOTE_W'($urandom_range(0, 127));
            end
        end else begin
            if (pick < 55) begin
                it.action = ACT_NOTE_ON;
                it.note   = pool_note();
            end else if (pick < 90) begin
                v       = $urandom_range(0, NV - 1);
                it.note = alloc_sb.gate[v] ? alloc_sb.vnote[v][NOTE_W-1:0] : pool_note();
            end else begin
                it.note = NOTE_W'($urandom_range(0, 127));
            end
        end
        return it;
    endfunction

    // Present one item and hold it until the block takes it.
    task automatic send_event(t_in_item it);
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        alloc_sb.note_input(it);
    endtask

    task automatic hold_off(int unsigned n);
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    // Drop valid and wait for every predicted command to come out.
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (alloc_sb.due_cmds.size() != 0) @(posedge i_clk);
    endtask

    // Mode writes only when idle. A resultless event may still be in the
    // pipe, so let it pass through before writing.
    task automatic write_mode(logic [MODE_W-1:0] m);
        settle();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= m;
        @(posedge i_clk);
        alloc_sb.write_mode(m);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic maybe_gap();
        if (!calm_tail && $urandom_range(0, 3) == 0) hold_off($urandom_range(1, 11));
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        logic [MODE_W-1:0] phase_modes [NUM_PHASES];
        phase_modes = '{MODE_POLY_RR, MODE_MONO, MODE_POLY_IDLE, MODE_LEGATO,
                        MODE_UNISON, MODE_SPARE_HI, MODE_LEGATO, MODE_LEGATO,
                        MODE_SPARE_LO, MODE_MONO, MODE_SPARE_MID, MODE_POLY_RR,
                        MODE_UNISON, MODE_POLY_IDLE};

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Round robin from reset: extremes of note/mask, retrigger of a
        // sounding voice, note-off of something not playing.
        send_event(mk_event(ACT_NOTE_ON,  7'd0,   6'h00));
        send_event(mk_event(ACT_NOTE_ON,  7'd127, 6'h3F));
        send_event(mk_event(ACT_NOTE_ON,  7'd0,   6'h00));
        send_event(mk_event(ACT_NOTE_OFF, 7'd127, 6'h3F));
        send_event(mk_event(ACT_NOTE_OFF, 7'd0,   6'h00));
        send_event(mk_event(ACT_NOTE_OFF, 7'd5,   6'h15));

        // Idle first: lowest idle voice, then fall back to round robin.
        write_mode(MODE_POLY_IDLE);
        send_event(mk_event(ACT_NOTE_ON,  7'd60, 6'h08));
        send_event(mk_event(ACT_NOTE_ON,  7'd61, 6'h00));
        send_event(mk_event(ACT_NOTE_OFF, 7'd60, 6'h2A));

        // Mono: lower entry removal is silent, top removal falls back,
        // unknown note ignored, last entry releases.
        write_mode(MODE_MONO);
        send_event(mk_event(ACT_NOTE_ON,  7'd10, 6'h00));
        send_event(mk_event(ACT_NOTE_ON,  7'd20, 6'h00));
        send_event(mk_event(ACT_NOTE_ON,  7'd30, 6'h00));
        send_event(mk_event(ACT_NOTE_OFF, 7'd20, 6'h00));
        send_event(mk_event(ACT_NOTE_OFF, 7'd30, 6'h00));
        send_event(mk_event(ACT_NOTE_OFF, 7'd99, 6'h00));
        send_event(mk_event(ACT_NOTE_OFF, 7'd10, 6'h00));

        // Legato: first note attacks, the rest glide.
        write_mode(MODE_LEGATO);
        send_event(mk_event(ACT_NOTE_ON,  7'd40, 6'h3F));
        send_event(mk_event(ACT_NOTE_ON,  7'd50, 6'h3F));
        send_event(mk_event(ACT_NOTE_OFF, 7'd50, 6'h3F));
        send_event(mk_event(ACT_NOTE_OFF, 7'd40, 6'h3F));

        // Unison: six results per note-on, stale note-off gives nothing.
        write_mode(MODE_UNISON);
        send_event(mk_event(ACT_NOTE_ON,  7'd70, 6'h00));
        send_event(mk_event(ACT_NOTE_ON,  7'd71, 6'h00));
        send_event(mk_event(ACT_NOTE_OFF, 7'd70, 6'h00));
        send_event(mk_event(ACT_NOTE_OFF, 7'd71, 6'h00));

        // Random phases across every mode code, the same mode written twice
        // in a row once; the last two phases run without idling.
        for (int p = 0; p < NUM_PHASES; p++) begin
            write_mode(phase_modes[p]);
            calm_tail = (p >= NUM_PHASES - 2);
            if (alloc_sb.is_stack_mode()) begin
                // run the stack past full so the oldest note gets dropped
                repeat ($urandom_range(17, 20)) begin
                    maybe_gap();
                    send_event(mk_event(ACT_NOTE_ON, pool_note(), rand_idle()));
                end
            end
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                maybe_gap();
                if ((p == 0 && k == 11) || (!calm_tail && $urandom_range(0, 59) == 0))
                    settle();
                send_event(random_event());
            end
        end

        settle();
        repeat (20) @(posedge i_clk);
        if (alloc_sb.due_cmds.size() != 0)
            alloc_sb.report($sformatf("%0d results never arrived", alloc_sb.due_cmds.size()));
        if (alloc_sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
